/* hw/rtl/mmvp_pkg.sv */
// Package for the modular matrix-vector product block.
// Holds field widths, operation codes and size defaults; no dependencies.
package mmvp_pkg;
	localparam int unsigned WordW = 64;
	localparam int unsigned IdxW = 3;
	localparam int unsigned InLimbsDef = 8;
	localparam int unsigned OutLimbsDef = 8;
	localparam logic OpLoad = 1'b0;
	localparam logic OpElem = 1'b1;

	typedef struct packed {
		logic start;
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
		logic [WordW-1:0] c;
		logic [WordW-1:0] m;
	} mac_req_t;
endpackage

/* hw/rtl/mmvp_mac.sv */
// Bit-serial modular multiply-accumulate unit: r = (c + a*b) mod m.
// Depends on mmvp_pkg. m of zero means modulo 2^64.
module mmvp_mac import mmvp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  mac_req_t         req,
	output logic             done,
	output logic [WordW-1:0] result
);
	localparam logic [2:0] SIdle = 3'd0;
	localparam logic [2:0] SRedC = 3'd1;
	localparam logic [2:0] SRedA = 3'd2;
	localparam logic [2:0] SMul = 3'd3;
	localparam logic [2:0] SAdd = 3'd4;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic [WordW-1:0] shf_q, a_q, b_q, m_q, acc_q, cred_q;
	logic [WordW:0] base, base_sub, sum, sum_sub;
	logic [WordW-1:0] base_r, sum_r, addend, one_m;
	logic mzero;

	// Each pass is an MSB-first Horner step: acc = (2*acc + bit*addend) mod m.
	// The sum and the element are reduced with an addend of one, then the product is formed.
	assign mzero = (m_q == '0);
	assign one_m = {{(WordW-1){1'b0}}, (m_q != {{(WordW-1){1'b0}}, 1'b1})};
	assign base = (state_q == SAdd) ? {1'b0, acc_q} : {acc_q, 1'b0};
	assign base_sub = base - {1'b0, m_q};
	assign base_r = (mzero || base_sub[WordW]) ? base[WordW-1:0] : base_sub[WordW-1:0];
	assign sum = {1'b0, base_r} + {1'b0, addend};
	assign sum_sub = sum - {1'b0, m_q};
	assign sum_r = (mzero || sum_sub[WordW]) ? sum[WordW-1:0] : sum_sub[WordW-1:0];

	always_comb begin
		case (state_q)
			SMul: addend = shf_q[WordW-1] ? a_q : '0;
			SAdd: addend = cred_q;
			default: addend = shf_q[WordW-1] ? one_m : '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SIdle;
			cnt_q <= '0;
			done <= 1'b0;
			result <= '0;
			shf_q <= '0;
			a_q <= '0;
			b_q <= '0;
			m_q <= '0;
			acc_q <= '0;
			cred_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				SIdle: begin
					if (req.start) begin
						m_q <= req.m;
						shf_q <= req.c;
						a_q <= req.a;
						b_q <= req.b;
						acc_q <= '0;
						cnt_q <= '0;
						state_q <= SRedC;
					end
				end
				SRedC: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						cred_q <= sum_r;
						acc_q <= '0;
						shf_q <= a_q;
						state_q <= SRedA;
					end else begin
						acc_q <= sum_r;
						shf_q <= {shf_q[WordW-2:0], 1'b0};
					end
				end
				SRedA: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						a_q <= sum_r;
						acc_q <= '0;
						shf_q <= b_q;
						state_q <= SMul;
					end else begin
						acc_q <= sum_r;
						shf_q <= {shf_q[WordW-2:0], 1'b0};
					end
				end
				SMul: begin
					cnt_q <= cnt_q + 6'd1;
					acc_q <= sum_r;
					shf_q <= {shf_q[WordW-2:0], 1'b0};
					if (cnt_q == 6'd63) state_q <= SAdd;
				end
				SAdd: begin
					result <= sum_r;
					done <= 1'b1;
					state_q <= SIdle;
				end
				default: state_q <= SIdle;
			endcase
		end
	end
endmodule

/* hw/rtl/modular_matrix_vector_product.sv */
// Top level of the modular matrix-vector product block.
// Depends on mmvp_pkg and mmvp_mac.
// Channel | Direction | Contents
// s_axis  | in        | tdata: row_index[2:0], col_index[5:3], value[69:6]; tuser: op
// m_axis  | out       | tdata: residue[63:0], column[66:64]; tlast: last_column
// cfg     | in        | modulus write
// A weight load leaves tready high. An element holds tready low through the work of every output
// column (weight read, start, three 64-step passes of the shared unit that reduce the sum,
// reduce the element and multiply, one add step and the hand-back of the result).
// After the element of the last row one result per column follows, at best one per cycle.
// Reset clears the column sums and sets the modulus to one.
// A stalled result holds the block until it is taken.
module modular_matrix_vector_product import mmvp_pkg::*; #(
	parameter int unsigned IN_LIMBS = InLimbsDef,
	parameter int unsigned OUT_LIMBS = OutLimbsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata, // row_index, col_index, value, zero fill
	input  logic        s_axis_tuser, // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata, // residue, column, zero fill
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);
	localparam int unsigned RowW = (IN_LIMBS > 1) ? $clog2(IN_LIMBS) : 1;
	localparam int unsigned ColW = (OUT_LIMBS > 1) ? $clog2(OUT_LIMBS) : 1;
	localparam int unsigned AddrW = (IN_LIMBS * OUT_LIMBS > 1) ?
		$clog2(IN_LIMBS * OUT_LIMBS) : 1;
	localparam logic [2:0] SIdle = 3'd0;
	localparam logic [2:0] SRd = 3'd1;
	localparam logic [2:0] SMac = 3'd2;
	localparam logic [2:0] SWait = 3'd3;
	localparam logic [2:0] SOut = 3'd4;

	logic [2:0] state_q;
	logic [WordW-1:0] modulus_q, x_q, w_q, res_q;
	logic [WordW-1:0] wmem [IN_LIMBS*OUT_LIMBS];
	logic [WordW-1:0] sums_q [OUT_LIMBS];
	logic [RowW-1:0] row_q;
	logic [ColW-1:0] col_q;
	logic last_row_q, mac_done;
	logic [WordW-1:0] mac_res;
	mac_req_t req;
	logic [2:0] in_row, in_col;
	logic [WordW-1:0] in_val;
	logic acc;

	assign in_row = s_axis_tdata[2:0];
	assign in_col = s_axis_tdata[5:3];
	assign in_val = s_axis_tdata[69:6];
	assign s_axis_tready = (state_q == SIdle);
	assign acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == SOut);
	assign m_axis_tdata = {5'd0, 3'(col_q), res_q};
	assign m_axis_tlast = (32'(col_q) == OUT_LIMBS - 1);

	assign req = {(state_q == SRd), x_q, w_q, sums_q[col_q], modulus_q};

	mmvp_mac u_mac (.clk(clk), .arst_n(arst_n), .req(req), .done(mac_done), .result(mac_res));

	always_ff @(posedge clk) begin
		if (acc && s_axis_tuser == OpLoad && 32'(in_row) < IN_LIMBS && 32'(in_col) < OUT_LIMBS)
			wmem[AddrW'(32'(in_row) * OUT_LIMBS + 32'(in_col))] <= in_val;
		w_q <= wmem[AddrW'(32'(row_q) * OUT_LIMBS + 32'(col_q))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SIdle;
			modulus_q <= 64'd1;
			col_q <= '0;
			row_q <= '0;
			x_q <= '0;
			res_q <= '0;
			last_row_q <= 1'b0;
			for (int i = 0; i < OUT_LIMBS; i++) sums_q[i] <= '0;
		end else begin
			if (cfg_we) modulus_q <= cfg_wdata;
			case (state_q)
				SIdle: begin
					if (acc && s_axis_tuser == OpElem && 32'(in_row) < IN_LIMBS) begin
						row_q <= RowW'(in_row);
						x_q <= in_val;
						last_row_q <= (32'(in_row) == IN_LIMBS - 1);
						col_q <= '0;
						state_q <= SMac;
					end
				end
				SMac: state_q <= SRd;
				SRd: state_q <= SWait;
				SWait: begin
					if (mac_done) begin
						sums_q[col_q] <= mac_res;
						if (32'(col_q) == OUT_LIMBS - 1) begin
							col_q <= '0;
							if (last_row_q) begin
								res_q <= (OUT_LIMBS == 1) ? mac_res : sums_q[0];
								state_q <= SOut;
							end else state_q <= SIdle;
						end else begin
							col_q <= col_q + 1'b1;
							state_q <= SMac;
						end
					end
				end
				SOut: begin
					if (m_axis_tready) begin
						sums_q[col_q] <= '0;
						if (32'(col_q) == OUT_LIMBS - 1) begin
							col_q <= '0;
							state_q <= SIdle;
						end else begin
							col_q <= col_q + 1'b1;
							res_q <= sums_q[col_q + 1'b1];
						end
					end
				end
				default: state_q <= SIdle;
			endcase
		end
	end
endmodule
